@@ src/spmq_pkg.sv @@
// ----------------------------------------------------------------------------
// spmq_pkg: shared definitions for the strict priority multi-queue
// Field widths, operation and status codes, and the scheduler control bundle.
// ----------------------------------------------------------------------------
package spmq_pkg;

	// Default sizes for the top-level parameters
	localparam int LEVELS_DEF      = 8;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;

	// Fixed field widths
	localparam int PRIO_W   = 4;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 8;
	localparam int LCOUNT_W = 5;

	typedef enum logic [0:0] {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_BAD_PRIO = 2'd3
	} status_t;

	// Decision of the scheduler for the transaction in stage 1
	typedef struct packed {
		status_t status;
		logic    rem_ok;      // a task is removed
		logic    wr_en;       // a task is appended
		logic    front_valid; // some task waits afterwards
		logic    front_byp;   // the new front is the task appended now
	} spmq_ctl_t;

endpackage

@@ src/spmq_sched.sv @@
// ----------------------------------------------------------------------------
// spmq_sched: per-level ring pointers, occupancy and level selection
// Decides one transaction per cycle, updates the pointers and counts, and
// produces the slot addresses for the write and the two reads.
// ----------------------------------------------------------------------------
module spmq_sched #(
	parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
	localparam int ADDR_W     = $clog2(LEVELS * LEVEL_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  spmq_pkg::func_t               func_s1,
	input  logic [spmq_pkg::PRIO_W-1:0]   prio_s1,
	output spmq_pkg::spmq_ctl_t           ctl,
	output logic [ADDR_W-1:0]             wr_addr,
	output logic [ADDR_W-1:0]             rem_addr,
	output logic [ADDR_W-1:0]             front_addr,
	output logic [spmq_pkg::PRIO_W-1:0]   rem_prio,
	output logic [spmq_pkg::PRIO_W-1:0]   front_prio,
	output logic [spmq_pkg::TOTAL_W-1:0]  total_count,
	output logic [spmq_pkg::LCOUNT_W-1:0] level_count
);
	import spmq_pkg::*;

	localparam int LVL_W = $clog2(LEVELS);
	localparam int PTR_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W = $clog2(LEVELS * LEVEL_DEPTH + 1);

	logic [PTR_W-1:0] head_q [LEVELS];
	logic [PTR_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] cnt_q  [LEVELS];
	logic [TOT_W-1:0] total_q;

	logic [PTR_W-1:0] head_n [LEVELS];
	logic [PTR_W-1:0] tail_n [LEVELS];
	logic [CNT_W-1:0] cnt_n  [LEVELS];
	logic [TOT_W-1:0] total_n;

	logic [LEVELS-1:0] busy_lv;
	logic [LEVELS-1:0] busy_lv_n;
	logic [LVL_W-1:0]  top;
	logic [LVL_W-1:0]  top_n;
	logic              any;
	logic              any_n;
	logic [PRIO_W-1:0] prio_m1;
	logic [LVL_W-1:0]  lv;
	logic              prio_ok;
	logic              full;
	logic              enq_ok;
	logic              deq_ok;
	status_t           status_c;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] l,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
	endfunction

	assign prio_m1 = prio_s1 - PRIO_W'(1);
	assign lv      = prio_m1[LVL_W-1:0];
	assign prio_ok = (prio_s1 != '0) && ({1'b0, prio_s1} <= (PRIO_W+1)'(LEVELS));

	// Highest non-empty level before the transaction
	always_comb begin
		top = '0;
		for (int i = 0; i < LEVELS; i++) begin
			busy_lv[i] = (cnt_q[i] != '0);
			if (busy_lv[i]) begin
				top = LVL_W'(i);
			end
		end
		any = |busy_lv;
	end

	assign full   = (cnt_q[lv] == CNT_W'(LEVEL_DEPTH));
	assign enq_ok = valid_s1 && (func_s1 == FUNC_ENQ) && prio_ok && !full;
	assign deq_ok = valid_s1 && (func_s1 == FUNC_DEQ) && any;

	always_comb begin
		priority if (func_s1 == FUNC_DEQ) begin
			status_c = any ? ST_OK : ST_EMPTY;
		end else if (!prio_ok) begin
			status_c = ST_BAD_PRIO;
		end else if (full) begin
			status_c = ST_FULL;
		end else begin
			status_c = ST_OK;
		end
	end

	// Next pointers and counts
	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			head_n[i] = head_q[i];
			tail_n[i] = tail_q[i];
			cnt_n[i]  = cnt_q[i];
			if (enq_ok && (lv == LVL_W'(i))) begin
				tail_n[i] = ring_next(tail_q[i]);
				cnt_n[i]  = cnt_q[i] + CNT_W'(1);
			end
			if (deq_ok && (top == LVL_W'(i))) begin
				head_n[i] = ring_next(head_q[i]);
				cnt_n[i]  = cnt_q[i] - CNT_W'(1);
			end
		end
		total_n = total_q + TOT_W'(enq_ok) - TOT_W'(deq_ok);
	end

	// Highest non-empty level after the transaction
	always_comb begin
		top_n = '0;
		for (int i = 0; i < LEVELS; i++) begin
			busy_lv_n[i] = (cnt_n[i] != '0);
			if (busy_lv_n[i]) begin
				top_n = LVL_W'(i);
			end
		end
		any_n = |busy_lv_n;
	end

	assign ctl.status      = status_c;
	assign ctl.rem_ok      = deq_ok;
	assign ctl.wr_en       = enq_ok;
	assign ctl.front_valid = any_n;
	assign ctl.front_byp   = enq_ok && (cnt_q[lv] == '0) && (top_n == lv);

	assign wr_addr    = slot_addr(lv, tail_q[lv]);
	assign rem_addr   = slot_addr(top, head_q[top]);
	assign front_addr = slot_addr(top_n, head_n[top_n]);

	assign rem_prio    = deq_ok ? PRIO_W'(top) + PRIO_W'(1) : '0;
	assign front_prio  = any_n ? PRIO_W'(top_n) + PRIO_W'(1) : '0;
	assign total_count = TOTAL_W'(total_n);
	assign level_count = prio_ok ? LCOUNT_W'(cnt_n[lv]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			total_q <= '0;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			cnt_q   <= cnt_n;
			total_q <= total_n;
		end
	end

endmodule

@@ src/strict_priority_multi_queue.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_queue: strict priority task queue, one FIFO per level
// Enqueue appends a task id to its level; dequeue pops the front of the
// highest non-empty level. Each transaction returns status, the removed task,
// the new overall front and the occupancy counts.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload
//  --------  ----------------  ---------------------------------------------
//  request   start / busy      func, task_id, priority_req
//  result    done (strobe)     status, removed_id, removed_priority,
//                              front_valid, front_id, front_priority,
//                              total_count, level_count
//
// Cycles: one transaction per cycle, back to back; the result strobes once the
// request has passed the input register and then the result register (taken
// together with the registered slot memory read).
// busy is always low: the pointers and counts settle within the cycle.
// Reset: arst_n clears pointers, counts and strobes; the slot memory is not
// cleared, only entries holding a task ever reach the outputs.
// Stalls: none; the receiver must take done on the cycle it is high.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
	parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
	parameter int ID_BITS     = spmq_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [ID_BITS-1:0]            task_id,
	input  logic [spmq_pkg::PRIO_W-1:0]   priority_req,
	output logic                          done,
	output logic [spmq_pkg::STATUS_W-1:0] status,
	output logic [ID_BITS-1:0]            removed_id,
	output logic [spmq_pkg::PRIO_W-1:0]   removed_priority,
	output logic                          front_valid,
	output logic [ID_BITS-1:0]            front_id,
	output logic [spmq_pkg::PRIO_W-1:0]   front_priority,
	output logic [spmq_pkg::TOTAL_W-1:0]  total_count,
	output logic [spmq_pkg::LCOUNT_W-1:0] level_count
);
	import spmq_pkg::*;

	localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	// Stage 1: request register
	logic              valid_s1;
	func_t             func_s1;
	logic [ID_BITS-1:0] id_s1;
	logic [PRIO_W-1:0] prio_s1;

	// Scheduler decision for stage 1
	spmq_ctl_t          ctl;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rem_addr;
	logic [ADDR_W-1:0]  front_addr;
	logic [PRIO_W-1:0]  rem_prio;
	logic [PRIO_W-1:0]  front_prio;
	logic [TOTAL_W-1:0] total_c;
	logic [LCOUNT_W-1:0] level_c;

	// Stage 2: result register
	logic                valid_s2;
	status_t             status_s2;
	logic                rem_ok_s2;
	logic [PRIO_W-1:0]   rem_prio_s2;
	logic                front_valid_s2;
	logic                front_byp_s2;
	logic [ID_BITS-1:0]  byp_id_s2;
	logic [PRIO_W-1:0]   front_prio_s2;
	logic [TOTAL_W-1:0]  total_s2;
	logic [LCOUNT_W-1:0] level_s2;
	logic [ID_BITS-1:0]  rd_rem_s2;
	logic [ID_BITS-1:0]  rd_front_s2;

	// Task slots, LEVEL_DEPTH per level, one write and two reads per cycle
	logic [ID_BITS-1:0] slot_mem [SLOTS];

	// Never hold off a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1 <= func_t'(func);
			id_s1   <= task_id;
			prio_s1 <= priority_req;
		end
	end

	spmq_sched #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_sched (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.func_s1     (func_s1),
		.prio_s1     (prio_s1),
		.ctl         (ctl),
		.wr_addr     (wr_addr),
		.rem_addr    (rem_addr),
		.front_addr  (front_addr),
		.rem_prio    (rem_prio),
		.front_prio  (front_prio),
		.total_count (total_c),
		.level_count (level_c)
	);

	// Append on enqueue; read the removed task and the new front. A read of
	// the slot written in the same cycle returns old data, so the new front
	// takes the bypass path below when it is the task appended now.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			slot_mem[wr_addr] <= id_s1;
		end
		rd_rem_s2   <= slot_mem[rem_addr];
		rd_front_s2 <= slot_mem[front_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result fields for the strobe cycle
	always_ff @(posedge clk) begin
		status_s2      <= ctl.status;
		rem_ok_s2      <= ctl.rem_ok;
		rem_prio_s2    <= rem_prio;
		front_valid_s2 <= ctl.front_valid;
		front_byp_s2   <= ctl.front_byp;
		byp_id_s2      <= id_s1;
		front_prio_s2  <= front_prio;
		total_s2       <= total_c;
		level_s2       <= level_c;
	end

	assign done             = valid_s2;
	assign status           = status_s2;
	assign removed_id       = rem_ok_s2 ? rd_rem_s2 : '0;
	assign removed_priority = rem_prio_s2;
	assign front_valid      = front_valid_s2;
	assign front_priority   = front_prio_s2;
	assign total_count      = total_s2;
	assign level_count      = level_s2;

	always_comb begin
		priority if (!front_valid_s2) begin
			front_id = '0;
		end else if (front_byp_s2) begin
			front_id = byp_id_s2;
		end else begin
			front_id = rd_front_s2;
		end
	end

endmodule

@@ src/spmq_checker.sv @@
// ----------------------------------------------------------------------------
// spmq_checker: port-level checks for the strict priority multi-queue
// Watches request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module spmq_checker #(
	parameter int ID_BITS = spmq_pkg::ID_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [spmq_pkg::STATUS_W-1:0] status,
	input logic [ID_BITS-1:0]            removed_id,
	input logic [spmq_pkg::PRIO_W-1:0]   removed_priority,
	input logic                          front_valid,
	input logic [ID_BITS-1:0]            front_id,
	input logic [spmq_pkg::PRIO_W-1:0]   front_priority
);
	import spmq_pkg::*;

	// Every taken request is followed by a result strobe
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("request without result");

	// No result without an earlier taken request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");

	// Empty dequeue removes nothing and leaves the queue empty
	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |->
			(removed_id == '0) && (removed_priority == '0) && !front_valid)
		else $error("empty dequeue reported a task");

	// Nothing waiting means no front task
	a_no_front: assert property (@(posedge clk) disable iff (!arst_n)
		done && !front_valid |-> (front_id == '0) && (front_priority == '0))
		else $error("front reported while empty");

	// A removed task only comes with an ok status
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (removed_priority != '0) |-> (status == ST_OK))
		else $error("removal with error status");

endmodule

bind strict_priority_multi_queue spmq_checker #(.ID_BITS(ID_BITS)) u_spmq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.status           (status),
	.removed_id       (removed_id),
	.removed_priority (removed_priority),
	.front_valid      (front_valid),
	.front_id         (front_id),
	.front_priority   (front_priority)
);
